### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked checks on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge
`define CHK_PROP(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// condition must never be true
`define CHK_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error(msg);

`endif

### rtl/htc_pkg.sv
// ---------------------------------------------------------------------------
// htc_pkg
// Field widths, codes and shared types of the Huffman table codec.
// ---------------------------------------------------------------------------
`default_nettype none

package htc_pkg;

	localparam int OP_W   = 2;
	localparam int SYM_W  = 8;
	localparam int CODE_W = 16;
	localparam int LEN_W  = 5;
	localparam int KIND_W = 2;

	typedef logic [OP_W-1:0]   op_t;
	typedef logic [KIND_W-1:0] kind_t;

	localparam op_t OP_LOAD   = 2'd0;
	localparam op_t OP_ENCODE = 2'd1;
	localparam op_t OP_DECODE = 2'd2;

	localparam kind_t KIND_CODE   = 2'd0;
	localparam kind_t KIND_SYMBOL = 2'd1;
	localparam kind_t KIND_ERROR  = 2'd2;

	// table access from the sequencer
	typedef struct packed {
		logic              wr;
		logic              rd;
		logic [SYM_W-1:0]  sym;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} tbl_cmd_t;

	typedef struct packed {
		kind_t             kind;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  length;
	} result_t;

endpackage

`default_nettype wire

### rtl/htc_if.sv
// ---------------------------------------------------------------------------
// Codec channels
// Request and response channels, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface htc_in_if;
	import htc_pkg::*;

	logic              valid;
	logic              ready;
	op_t               operation;
	logic [SYM_W-1:0]  symbol;
	logic [CODE_W-1:0] code_word;
	logic [LEN_W-1:0]  code_length;
	logic              bit_in;

	modport source (output valid, operation, symbol, code_word, code_length, bit_in,
		input ready);
	modport sink (input valid, operation, symbol, code_word, code_length, bit_in,
		output ready);
endinterface

interface htc_out_if;
	import htc_pkg::*;

	logic              valid;
	logic              ready;
	kind_t             result_kind;
	logic [SYM_W-1:0]  out_symbol;
	logic [CODE_W-1:0] out_code;
	logic [LEN_W-1:0]  out_length;

	modport source (output valid, result_kind, out_symbol, out_code, out_length,
		input ready);
	modport sink (input valid, result_kind, out_symbol, out_code, out_length,
		output ready);
endinterface

`default_nettype wire

### rtl/huffman_table_codec_unit.sv
// ---------------------------------------------------------------------------
// huffman_table_codec_unit
// Loadable Huffman code table with per-symbol encode and bit-serial decode.
// ---------------------------------------------------------------------------
//  channel   | role   | item
//  ----------+--------+------------------------------------------------
//  request   | sink   | load entry / encode symbol / decode one bit
//  response  | source | code word, decoded symbol or decode error
//
//  Encode: table read, then result build. Decode: the single read port of the
//  table is walked one entry per cycle and the first matching entry wins.
//  Reset clears all entry valid bits at once; no clearing pass.
//  One result waits in the output register while the next item is taken;
//  a further result holds the sequencer until the register frees up.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module huffman_table_codec_unit #(
	parameter int MAX_CODE_LEN = 16,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	htc_in_if.sink    request,
	htc_out_if.source response
);
	import htc_pkg::*;

	localparam int LEN_LIMIT = (MAX_CODE_LEN < 16) ? MAX_CODE_LEN : 16;
	localparam int LW        = $clog2(LEN_LIMIT + 1);
	localparam int CW        = LEN_LIMIT;

	tbl_cmd_t      cmd;
	logic [LW-1:0] rd_len;
	logic [CW-1:0] rd_code;
	result_t       res;
	logic          res_valid;
	logic          res_ready;
	logic          out_valid_q;
	result_t       out_q;

	htc_seq #(
		.SYMBOL_COUNT (SYMBOL_COUNT),
		.LEN_LIMIT    (LEN_LIMIT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cmd       (cmd),
		.rd_len    (rd_len),
		.rd_code   (rd_code),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	htc_store #(
		.SYMBOL_COUNT (SYMBOL_COUNT),
		.LEN_LIMIT    (LEN_LIMIT)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_len  (rd_len),
		.rd_code (rd_code)
	);

	assign res_ready = !out_valid_q || response.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign response.valid       = out_valid_q;
	assign response.result_kind = out_q.kind;
	assign response.out_symbol  = out_q.symbol;
	assign response.out_code    = out_q.code;
	assign response.out_length  = out_q.length;

	`CHK_NEVER(a_res_while_idle, res_valid && request.ready, "result pending while idle")
	`CHK_PROP(a_decode_busy, request.valid && request.ready && request.operation == OP_DECODE |=> !request.ready, "decode item did not start a scan")
	`CHK_PROP(a_empty_fields, out_valid_q && out_q.kind != KIND_CODE |-> out_q.code == '0 && out_q.length == '0, "symbol or error item carries code bits")

endmodule

`default_nettype wire

### rtl/htc_ram.sv
// ---------------------------------------------------------------------------
// htc_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module htc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/htc_store.sv
// ---------------------------------------------------------------------------
// htc_store
// Code table: length and code per symbol in one RAM, plus per-entry valid
// bits so that every length reads zero after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module htc_store #(
	parameter int SYMBOL_COUNT = 256,
	parameter int LEN_LIMIT    = 16,
	localparam int AW = $clog2(SYMBOL_COUNT),
	localparam int LW = $clog2(LEN_LIMIT + 1),
	localparam int CW = LEN_LIMIT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  htc_pkg::tbl_cmd_t cmd,
	output logic [LW-1:0]     rd_len,
	output logic [CW-1:0]     rd_code
);
	import htc_pkg::*;

	logic [AW-1:0]           addr;
	logic [LW-1:0]           wr_len;
	logic [CW-1:0]           len_mask;
	logic [CW-1:0]           wr_code;
	logic [LW+CW-1:0]        rd_entry;
	logic [SYMBOL_COUNT-1:0] valid_q;
	logic                    rd_valid_q;

	assign addr = cmd.sym[AW-1:0];

	// saturate length, drop code bits above it
	always_comb begin
		if (cmd.len > LEN_W'(LEN_LIMIT)) begin
			wr_len = LW'(LEN_LIMIT);
		end else begin
			wr_len = LW'(cmd.len);
		end
		for (int i = 0; i < CW; i++) begin
			len_mask[i] = (i < int'(wr_len));
		end
		wr_code = cmd.code[CW-1:0] & len_mask;
	end

	htc_ram #(
		.WIDTH (LW + CW),
		.DEPTH (SYMBOL_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (addr),
		.wdata ({wr_len, wr_code}),
		.re    (cmd.rd),
		.raddr (addr),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.wr) begin
				valid_q[addr] <= 1'b1;
			end
			if (cmd.rd) begin
				rd_valid_q <= valid_q[addr];
			end
		end
	end

	assign rd_len  = rd_valid_q ? rd_entry[LW+CW-1:CW] : '0;
	assign rd_code = rd_entry[CW-1:0];

endmodule

`default_nettype wire

### rtl/htc_seq.sv
// ---------------------------------------------------------------------------
// htc_seq
// Item sequencer: table loads, encode lookups, and the decode scan that
// shifts each code bit into the accumulator and walks the table one entry
// per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module htc_seq #(
	parameter int SYMBOL_COUNT = 256,
	parameter int LEN_LIMIT    = 16,
	localparam int AW = $clog2(SYMBOL_COUNT),
	localparam int LW = $clog2(LEN_LIMIT + 1),
	localparam int CW = LEN_LIMIT
) (
	input  logic              clk,
	input  logic              arst_n,
	htc_in_if.sink            request,
	output htc_pkg::tbl_cmd_t cmd,
	input  logic [LW-1:0]     rd_len,
	input  logic [CW-1:0]     rd_code,
	output htc_pkg::result_t  res,
	output logic              res_valid,
	input  logic              res_ready
);
	import htc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ENC  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	localparam logic [AW-1:0] LAST_IDX = AW'(SYMBOL_COUNT - 1);

	logic [1:0]    state_q;
	logic [CW-1:0] acc_q;
	logic [LW-1:0] cnt_q;
	logic [AW-1:0] idx_q;
	logic          issue_q;
	logic          chk_s1;
	logic [AW-1:0] chk_idx_s1;
	logic          enc_hit_q;
	result_t       res_q;

	logic take;
	logic in_range;
	logic hit;
	logic scan_end;
	logic limit_hit;

	assign request.ready = (state_q == ST_IDLE);
	assign take          = request.valid && request.ready;
	assign in_range      = {1'b0, request.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);

	assign hit       = chk_s1 && (rd_len != '0) && (rd_len == cnt_q) && (rd_code == acc_q);
	assign scan_end  = chk_s1 && !hit && (chk_idx_s1 == LAST_IDX);
	assign limit_hit = (cnt_q == LW'(LEN_LIMIT));

	always_comb begin
		cmd = '0;
		if (state_q == ST_SCAN) begin
			cmd.rd  = issue_q;
			cmd.sym = SYM_W'(idx_q);
		end else if (take && in_range) begin
			cmd.wr   = (request.operation == OP_LOAD);
			cmd.rd   = (request.operation == OP_ENCODE);
			cmd.sym  = request.symbol;
			cmd.len  = request.code_length;
			cmd.code = request.code_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			acc_q     <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			issue_q   <= 1'b0;
			chk_s1    <= 1'b0;
			enc_hit_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						priority case (request.operation)
							OP_ENCODE: begin
								enc_hit_q <= in_range;
								state_q   <= ST_ENC;
							end
							OP_DECODE: begin
								acc_q   <= CW'({acc_q, request.bit_in});
								cnt_q   <= cnt_q + 1'b1;
								idx_q   <= '0;
								issue_q <= 1'b1;
								chk_s1  <= 1'b0;
								state_q <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_ENC: begin
					state_q <= ST_OUT;
				end
				ST_SCAN: begin
					if (hit) begin
						acc_q   <= '0;
						cnt_q   <= '0;
						issue_q <= 1'b0;
						chk_s1  <= 1'b0;
						state_q <= ST_OUT;
					end else if (scan_end) begin
						chk_s1 <= 1'b0;
						if (limit_hit) begin
							acc_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						chk_s1 <= issue_q;
						if (issue_q) begin
							idx_q <= idx_q + 1'b1;
							if (idx_q == LAST_IDX) begin
								issue_q <= 1'b0;
							end
						end
					end
				end
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			chk_idx_s1 <= idx_q;
		end
		if (state_q == ST_ENC) begin
			if (enc_hit_q && rd_len != '0) begin
				res_q <= {KIND_CODE, {SYM_W{1'b0}}, CODE_W'(rd_code), LEN_W'(rd_len)};
			end else begin
				res_q <= {KIND_CODE, {SYM_W{1'b0}}, {CODE_W{1'b0}}, {LEN_W{1'b0}}};
			end
		end else if (state_q == ST_SCAN && hit) begin
			res_q <= {KIND_SYMBOL, SYM_W'(chk_idx_s1), {CODE_W{1'b0}}, {LEN_W{1'b0}}};
		end else if (state_q == ST_SCAN && scan_end) begin
			res_q <= {KIND_ERROR, {SYM_W{1'b0}}, {CODE_W{1'b0}}, {LEN_W{1'b0}}};
		end
	end

	assign res       = res_q;
	assign res_valid = (state_q == ST_OUT);

endmodule

`default_nettype wire
